// File: hdl/first_fit_block_allocator_defines.svh
// Assertion macros shared by the checker of the first-fit block allocator.
// Needs nothing else; the including file supplies clock and reset names.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ffba check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ffba check failed");

`endif

// File: hdl/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
// Used by the controller, the datapath, the top level and the checker.
package ffba_pkg;

	localparam int ADDR_W     = 48;
	localparam int REQ_W      = 16;
	localparam int GRAN_BYTES = 16;
	localparam int GRAN_SHIFT = 4;
	// Granules needed: (request + header + 15) / 16, at most 13 bits.
	localparam int NEED_W     = REQ_W + 1 - GRAN_SHIFT;
	localparam int NEED_ROUND = 2 * GRAN_BYTES - 1;
	localparam int MIN_LEFT   = 2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_NULL  = 2'd2,
		ST_RANGE = 2'd3
	} res_status_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_INIT,
		CMD_LOAD,
		CMD_READ_NX,
		CMD_READ_B,
		CMD_READ_CUR,
		CMD_STEP,
		CMD_ALLOC_UNLINK,
		CMD_ALLOC_SHRINK,
		CMD_ALLOC_CARVE,
		CMD_FREE_INSERT,
		CMD_FREE_LINK,
		CMD_MERGE_BN,
		CMD_CLEAR_NX,
		CMD_MERGE_CB,
		CMD_CUR_SIZE_READ_B,
		CMD_CLEAR_B,
		CMD_RESULT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		res_status_t res;
	} cmd_t;

	typedef struct packed {
		logic op_free;
		logic req_zero;
		logic addr_zero;
		logic out_of_range;
		logic walk_alloc;
		logic walk_free;
		logic fits;
		logic small_left;
		logic merge_next;
		logic merge_prev;
		logic cur_root;
	} dp_stat_t;

endpackage

// File: hdl/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the block header store.
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/ffba_ctrl.sv
// Sequencer of the first-fit block allocator: walks the allocate and free
// procedures and drives the datapath by command. Depends on ffba_pkg.
module ffba_ctrl import ffba_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t dp_stat,
	output cmd_t     cmd
);

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_CHECK,
		S_A_LOOP,
		S_A_EVAL,
		S_A_UNLINK,
		S_A_CARVE,
		S_F_LOOP,
		S_F_WALK,
		S_F_INS,
		S_F_LINK,
		S_F_M1CHK,
		S_F_M1A,
		S_F_M1B,
		S_F_M2CHK,
		S_F_M2R,
		S_F_M2C,
		S_F_M2D,
		S_RESULT
	} state_t;

	state_t      state_q, state_d;
	res_status_t res_q, res_d;
	logic        out_valid_q;
	logic        slot_free;
	logic        post;

	// A new result may be written when the output register is empty or drains now.
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		post    = 1'b0;
		cmd     = '{op: CMD_NONE, res: ST_OK};
		unique case (state_q)
			S_INIT: begin
				cmd.op  = CMD_INIT;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = CMD_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!dp_stat.op_free) begin
					if (dp_stat.req_zero) begin
						res_d   = ST_NOFIT;
						state_d = S_RESULT;
					end else begin
						state_d = S_A_LOOP;
					end
				end else if (dp_stat.addr_zero) begin
					res_d   = ST_NULL;
					state_d = S_RESULT;
				end else if (dp_stat.out_of_range) begin
					res_d   = ST_RANGE;
					state_d = S_RESULT;
				end else begin
					state_d = S_F_LOOP;
				end
			end
			S_A_LOOP: begin
				if (dp_stat.walk_alloc) begin
					cmd.op  = CMD_READ_NX;
					state_d = S_A_EVAL;
				end else begin
					res_d   = ST_NOFIT;
					state_d = S_RESULT;
				end
			end
			S_A_EVAL: begin
				if (!dp_stat.fits) begin
					cmd.op  = CMD_STEP;
					state_d = S_A_LOOP;
				end else if (dp_stat.small_left) begin
					state_d = S_A_UNLINK;
				end else begin
					cmd.op  = CMD_ALLOC_SHRINK;
					state_d = S_A_CARVE;
				end
			end
			S_A_UNLINK: begin
				if (slot_free) begin
					cmd.op  = CMD_ALLOC_UNLINK;
					post    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_A_CARVE: begin
				if (slot_free) begin
					cmd.op  = CMD_ALLOC_CARVE;
					post    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_F_LOOP: begin
				if (dp_stat.walk_free) begin
					cmd.op  = CMD_READ_NX;
					state_d = S_F_WALK;
				end else begin
					cmd.op  = CMD_READ_B;
					state_d = S_F_INS;
				end
			end
			S_F_WALK: begin
				cmd.op  = CMD_STEP;
				state_d = S_F_LOOP;
			end
			S_F_INS: begin
				cmd.op  = CMD_FREE_INSERT;
				state_d = S_F_LINK;
			end
			S_F_LINK: begin
				cmd.op  = CMD_FREE_LINK;
				state_d = S_F_M1CHK;
			end
			S_F_M1CHK: begin
				if (dp_stat.merge_next) begin
					cmd.op  = CMD_READ_NX;
					state_d = S_F_M1A;
				end else begin
					state_d = S_F_M2CHK;
				end
			end
			S_F_M1A: begin
				cmd.op  = CMD_MERGE_BN;
				state_d = S_F_M1B;
			end
			S_F_M1B: begin
				cmd.op  = CMD_CLEAR_NX;
				state_d = S_F_M2CHK;
			end
			S_F_M2CHK: begin
				if (dp_stat.cur_root) begin
					res_d   = ST_OK;
					state_d = S_RESULT;
				end else begin
					cmd.op  = CMD_READ_CUR;
					state_d = S_F_M2R;
				end
			end
			S_F_M2R: begin
				cmd.op  = CMD_CUR_SIZE_READ_B;
				state_d = S_F_M2C;
			end
			S_F_M2C: begin
				if (dp_stat.merge_prev) begin
					cmd.op  = CMD_MERGE_CB;
					state_d = S_F_M2D;
				end else begin
					res_d   = ST_OK;
					state_d = S_RESULT;
				end
			end
			S_F_M2D: begin
				cmd.op  = CMD_CLEAR_B;
				res_d   = ST_OK;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (slot_free) begin
					cmd.op  = CMD_RESULT;
					cmd.res = res_q;
					post    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			res_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (post) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: hdl/ffba_dp.sv
// Datapath of the first-fit block allocator: list head, walk registers,
// header RAM and result register. Depends on ffba_pkg and ffba_ram.
module ffba_dp import ffba_pkg::*; #(
	parameter int ARENA_BYTES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_base,
	input  logic              op,
	input  logic [REQ_W-1:0]  request_bytes,
	input  logic [ADDR_W-1:0] free_address,
	input  cmd_t              cmd,
	output dp_stat_t          dp_stat,
	output logic [ADDR_W-1:0] block_address,
	output res_status_t       res_status
);

	localparam int GRAN = ARENA_BYTES / GRAN_BYTES;
	localparam int IW   = $clog2(GRAN);
	localparam int SW   = $clog2(GRAN + 1);
	localparam int CW   = SW;
	localparam int HW   = SW + IW + 1;

	// Control and configuration state.
	logic [ADDR_W-1:0] base_q;
	logic [IW-1:0]     head_q;
	logic              head_v_q;

	// Per-item registers.
	logic              op_q;
	logic              req_zero_q;
	logic              addr_zero_q;
	logic [NEED_W-1:0] need_q;
	logic [ADDR_W-1:0] off_q;
	logic [IW-1:0]     nx_q;
	logic              nv_q;
	logic [IW-1:0]     cur_q;
	logic              cur_root_q;
	logic [SW-1:0]     cur_size_q;
	logic [SW-1:0]     bsize_q;
	logic [CW-1:0]     steps_q;
	logic [ADDR_W-1:0] res_addr_q;
	res_status_t       res_status_q;

	// Header RAM ports. A header is {size, next, next valid}.
	logic          ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [HW-1:0] ram_wdata, ram_rdata;
	logic [SW-1:0] rd_size;
	logic [IW-1:0] rd_next;
	logic          rd_nv;

	logic [REQ_W:0]    need_sum;
	logic [IW-1:0]     b_idx;
	logic [SW-1:0]     remain;
	logic [IW:0]       carve_sum;
	logic [IW-1:0]     carve_idx;
	logic              carve_ok;
	logic [IW-1:0]     pay_g;
	logic [ADDR_W-1:0] pay_addr;

	ffba_ram #(
		.WIDTH(HW),
		.DEPTH(GRAN)
	) u_hdr_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_size = ram_rdata[HW-1 -: SW];
	assign rd_next = ram_rdata[IW:1];
	assign rd_nv   = ram_rdata[0];

	assign need_sum  = {1'b0, request_bytes} + (REQ_W + 1)'(NEED_ROUND);
	assign b_idx     = off_q[IW+GRAN_SHIFT-1:GRAN_SHIFT] - IW'(1);
	assign remain    = rd_size - SW'(need_q);
	assign carve_sum = {1'b0, nx_q} + (IW + 1)'(remain);
	assign carve_idx = carve_sum[IW-1:0];
	assign carve_ok  = carve_sum < (IW + 1)'(GRAN);

	// Payload address of a granule: base + 16 * (granule + 1).
	assign pay_g    = (cmd.op == CMD_ALLOC_CARVE) ? carve_idx : nx_q;
	assign pay_addr = base_q + (ADDR_W'(pay_g) << GRAN_SHIFT) + ADDR_W'(GRAN_BYTES);

	always_comb begin
		dp_stat.op_free      = op_q;
		dp_stat.req_zero     = req_zero_q;
		dp_stat.addr_zero    = addr_zero_q;
		dp_stat.out_of_range = (off_q < ADDR_W'(GRAN_BYTES)) ||
			(off_q >= ADDR_W'(ARENA_BYTES));
		dp_stat.walk_alloc   = nv_q && (steps_q < CW'(GRAN));
		dp_stat.walk_free    = nv_q && (steps_q < CW'(GRAN)) && (nx_q < b_idx);
		dp_stat.fits         = NEED_W'(rd_size) >= need_q;
		dp_stat.small_left   = remain < SW'(MIN_LEFT);
		dp_stat.merge_next   = nv_q &&
			(({1'b0, b_idx} + (IW + 1)'(bsize_q)) == {1'b0, nx_q});
		dp_stat.merge_prev   =
			(({1'b0, cur_q} + (IW + 1)'(cur_size_q)) == {1'b0, b_idx});
		dp_stat.cur_root     = cur_root_q;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = '0;
		ram_raddr = '0;
		ram_wdata = '0;
		unique case (cmd.op)
			CMD_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = {SW'(GRAN), IW'(0), 1'b0};
			end
			CMD_READ_NX: begin
				ram_re    = 1'b1;
				ram_raddr = nx_q;
			end
			CMD_READ_B, CMD_CUR_SIZE_READ_B: begin
				ram_re    = 1'b1;
				ram_raddr = b_idx;
			end
			CMD_READ_CUR: begin
				ram_re    = 1'b1;
				ram_raddr = cur_q;
			end
			CMD_ALLOC_UNLINK: begin
				ram_we    = !cur_root_q;
				ram_waddr = cur_q;
				ram_wdata = {cur_size_q, rd_next, rd_nv};
			end
			CMD_ALLOC_SHRINK: begin
				ram_we    = 1'b1;
				ram_waddr = nx_q;
				ram_wdata = {remain, rd_next, rd_nv};
			end
			CMD_ALLOC_CARVE: begin
				ram_we    = carve_ok;
				ram_waddr = carve_idx;
				ram_wdata = {SW'(need_q), IW'(0), 1'b0};
			end
			CMD_FREE_INSERT: begin
				ram_we    = 1'b1;
				ram_waddr = b_idx;
				ram_wdata = {rd_size, nx_q, nv_q};
			end
			CMD_FREE_LINK: begin
				ram_we    = !cur_root_q;
				ram_waddr = cur_q;
				ram_wdata = {cur_size_q, b_idx, 1'b1};
			end
			CMD_MERGE_BN: begin
				ram_we    = 1'b1;
				ram_waddr = b_idx;
				ram_wdata = {bsize_q + rd_size, rd_next, rd_nv};
			end
			CMD_CLEAR_NX: begin
				ram_we    = 1'b1;
				ram_waddr = nx_q;
			end
			CMD_MERGE_CB: begin
				ram_we    = 1'b1;
				ram_waddr = cur_q;
				ram_wdata = {cur_size_q + rd_size, rd_next, rd_nv};
			end
			CMD_CLEAR_B: begin
				ram_we    = 1'b1;
				ram_waddr = b_idx;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			head_q   <= '0;
			head_v_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_base;
			end
			if (cmd.op == CMD_ALLOC_UNLINK && cur_root_q) begin
				head_q   <= rd_next;
				head_v_q <= rd_nv;
			end else if (cmd.op == CMD_FREE_LINK && cur_root_q) begin
				head_q   <= b_idx;
				head_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CMD_LOAD: begin
				op_q        <= op;
				req_zero_q  <= (request_bytes == '0);
				addr_zero_q <= (free_address == '0);
				need_q      <= need_sum[REQ_W:GRAN_SHIFT];
				off_q       <= free_address - base_q;
				nx_q        <= head_q;
				nv_q        <= head_v_q;
				cur_root_q  <= 1'b1;
				steps_q     <= '0;
			end
			CMD_STEP: begin
				cur_q      <= nx_q;
				cur_root_q <= 1'b0;
				cur_size_q <= rd_size;
				nv_q       <= rd_nv;
				nx_q       <= rd_next;
				steps_q    <= steps_q + CW'(1);
			end
			CMD_ALLOC_UNLINK, CMD_ALLOC_CARVE: begin
				res_addr_q   <= pay_addr;
				res_status_q <= ST_OK;
			end
			CMD_FREE_INSERT: begin
				bsize_q <= rd_size;
			end
			CMD_CUR_SIZE_READ_B: begin
				cur_size_q <= rd_size;
			end
			CMD_RESULT: begin
				res_addr_q   <= '0;
				res_status_q <= cmd.res;
			end
			default: begin
				res_status_q <= res_status_q;
			end
		endcase
	end

	assign block_address = res_addr_q;
	assign res_status    = res_status_q;

endmodule

// File: hdl/first_fit_block_allocator.sv
// First-fit block allocator over one arena of 16-byte granules.
// Top level: joins the sequencer and the datapath. Depends on ffba_pkg.
//
// Requests enter on in_valid/in_stall with op (0 allocate, 1 free),
// request_bytes and free_address; one result leaves on out_valid/out_stall
// with block_address and status. arena_base is written on cfg_valid/cfg_ready
// (cfg_ready is always high); the user must write it only while no request
// is in flight, which the block does not enforce. One request is worked on
// at a time; in_stall is high from acceptance until its result has been
// placed in the output register. Each free-list node visited takes one header
// RAM read and one evaluation, since the next link comes out of the registered
// read port. An allocate walks until the first node that fits; a free walks
// to the insertion point and may then coalesce with the neighbouring blocks.
// Zero-size allocations and null or outside frees skip the walk. A walk
// visits at most ARENA_BYTES/16 nodes.
// A result waits in the output register while out_stall is high; the next
// request is still accepted and runs until it has its own result ready.
// After reset the arena is one free block; the init state writes its header,
// with in_stall high. Reset also clears arena_base to zero.
module first_fit_block_allocator import ffba_pkg::*; #(
	parameter int ARENA_BYTES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ADDR_W-1:0] arena_base,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [REQ_W-1:0]  request_bytes,
	input  logic [ADDR_W-1:0] free_address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ADDR_W-1:0] block_address,
	output logic [1:0]        status
);

	dp_stat_t    dp_stat;
	cmd_t        cmd;
	res_status_t res_status;

	assign cfg_ready = 1'b1;

	ffba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dp_stat  (dp_stat),
		.cmd      (cmd)
	);

	ffba_dp #(
		.ARENA_BYTES(ARENA_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid),
		.cfg_base     (arena_base),
		.op           (op),
		.request_bytes(request_bytes),
		.free_address (free_address),
		.cmd          (cmd),
		.dp_stat      (dp_stat),
		.block_address(block_address),
		.res_status   (res_status)
	);

	assign status = res_status;

endmodule

// File: hdl/ffba_checker.sv
// Port-level checks of the first-fit block allocator, bound to its top level.
// Depends on ffba_pkg and first_fit_block_allocator_defines.svh.
`include "first_fit_block_allocator_defines.svh"

module ffba_checker import ffba_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [ADDR_W-1:0] block_address,
	input logic [1:0]        status
);

	// One request at a time: the block is busy right after an acceptance.
	`FFBA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// A result never shows up in the cycle after its request was accepted.
	`FFBA_ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_valid && !in_stall, !$rose(out_valid))

	// Every result whose status is not OK (failed allocations, null and out-of-range frees) reports a zero address.
	`FFBA_ASSERT_NOW(a_fail_zero_addr, clk, arst_n, out_valid && (status != ST_OK), block_address == '0)

	// A stalled result stays put.
	`FFBA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(block_address) && $stable(status))

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

// File: dv/first_fit_block_allocator_tb.sv
// Self-checking testbench for the first-fit block allocator: directed cases, then random
// allocate/free traffic under several arena_base settings, checked against a free-list predictor.
// Depends on ffba_pkg and first_fit_block_allocator.
module first_fit_block_allocator_tb import ffba_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ARENA_BYTES = 4096;
	localparam int GRAN = ARENA_BYTES / GRAN_BYTES;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;
	localparam logic [ADDR_W-1:0] ARENA_END = ADDR_W'(ARENA_BYTES);
	localparam logic [ADDR_W-1:0] GRAN_SPAN = ADDR_W'(GRAN_BYTES);
	localparam int N_OPENING = 22;
	localparam int N_PHASES = 5;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 600;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		res_status_t status;
	} alloc_result_t;

	typedef struct {
		logic op;
		logic [REQ_W-1:0] req;
		logic [ADDR_W-1:0] faddr;
		bit fixed;
		logic [ADDR_W-1:0] exp_addr;
		res_status_t exp_status;
	} opening_case_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ADDR_W-1:0] cfg_base = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = 1'b0;
	logic [REQ_W-1:0] request_bytes = '0;
	logic [ADDR_W-1:0] free_address = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ADDR_W-1:0] block_address;
	logic [1:0] status;

	first_fit_block_allocator #(.ARENA_BYTES(ARENA_BYTES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.arena_base(cfg_base),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.request_bytes(request_bytes),
		.free_address(free_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.block_address(block_address),
		.status(status)
	);

	always #1 clk = ~clk;

	// Predictor state: the arena base and the header of every granule.
	logic [ADDR_W-1:0] base_model;
	int unsigned head_gran;
	bit head_valid;
	int unsigned hdr_size [GRAN];
	int unsigned hdr_next [GRAN];
	bit hdr_nvalid [GRAN];

	alloc_result_t owed_results [$];
	int unsigned live_granules [$];
	int error_count = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	bit long_hold_req = 1'b0;

	opening_case_t opening [N_OPENING] = '{
		'{OP_ALLOC, 16'd0, 48'd0, 1'b1, 48'd0, ST_NOFIT},
		'{OP_FREE, 16'hFFFF, 48'd0, 1'b1, 48'd0, ST_NULL},
		'{OP_FREE, 16'd0, 48'd15, 1'b1, 48'd0, ST_RANGE},
		'{OP_FREE, 16'd0, 48'd4096, 1'b1, 48'd0, ST_RANGE},
		'{OP_FREE, 16'd0, 48'hFFFF_FFFF_FFFF, 1'b1, 48'd0, ST_RANGE},
		'{OP_ALLOC, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 48'd0, ST_NOFIT},
		'{OP_ALLOC, 16'd4081, 48'd0, 1'b1, 48'd0, ST_NOFIT},
		'{OP_ALLOC, 16'd1, 48'hFFFF_FFFF_FFFF, 1'b1, 48'd4080, ST_OK},
		'{OP_ALLOC, 16'd32, 48'hAAAA_5555_0010, 1'b0, 48'd0, ST_OK},
		'{OP_ALLOC, 16'd4000, 48'd0, 1'b0, 48'd0, ST_OK},
		'{OP_ALLOC, 16'd1, 48'd0, 1'b0, 48'd0, ST_OK},
		'{OP_FREE, 16'hFFFF, 48'd4095, 1'b1, 48'd0, ST_OK},
		'{OP_FREE, 16'd0, 48'd4032, 1'b0, 48'd0, ST_OK},
		'{OP_ALLOC, 16'd48, 48'd0, 1'b0, 48'd0, ST_OK},
		'{OP_FREE, 16'd0, 48'd4032, 1'b0, 48'd0, ST_OK},
		'{OP_FREE, 16'd0, 48'd16, 1'b0, 48'd0, ST_OK},
		'{OP_ALLOC, 16'd100, 48'd0, 1'b0, 48'd0, ST_OK},
		'{OP_ALLOC, 16'd100, 48'd0, 1'b0, 48'd0, ST_OK},
		'{OP_FREE, 16'd0, 48'd3984, 1'b0, 48'd0, ST_OK},
		'{OP_FREE, 16'd0, 48'd3856, 1'b0, 48'd0, ST_OK},
		'{OP_ALLOC, 16'd4065, 48'd0, 1'b0, 48'd0, ST_OK},
		'{OP_FREE, 16'd0, 48'd16, 1'b0, 48'd0, ST_OK}
	};

	function automatic logic [ADDR_W-1:0] payload_of(int unsigned g);
		return base_model + ADDR_W'((g + 1) * GRAN_BYTES);
	endfunction

	// Block n lies right behind block p and is absorbed into it.
	function automatic void join_blocks(int unsigned p, int unsigned n);
		int unsigned nn;
		bit nv;
		nn = hdr_next[n];
		nv = hdr_nvalid[n];
		hdr_size[p] += hdr_size[n];
		hdr_next[p] = nn;
		hdr_nvalid[p] = nv;
		hdr_size[n] = 0;
		hdr_next[n] = 0;
		hdr_nvalid[n] = 1'b0;
	endfunction

	function automatic alloc_result_t predict_allocator(logic op_i, logic [REQ_W-1:0] req,
			logic [ADDR_W-1:0] fa);
		alloc_result_t res;
		logic [ADDR_W-1:0] off;
		int unsigned need, cur, prev, remain, n, b, nx, steps;
		bit cv, prev_root, nv;
		res.addr = '0;
		res.status = ST_OK;
		if (op_i == OP_ALLOC) begin
			if (req == '0) begin
				res.status = ST_NOFIT;
				return res;
			end
			need = (int'(req) + NEED_ROUND) / GRAN_BYTES;
			cur = head_gran;
			cv = head_valid;
			prev = 0;
			prev_root = 1'b1;
			// Walks are cut off after one step per granule, so a looped list still ends.
			for (steps = 0; cv && steps < GRAN; steps++) begin
				if (cur >= GRAN)
					break;
				if (hdr_size[cur] >= need) begin
					remain = hdr_size[cur] - need;
					if (remain < MIN_LEFT) begin
						if (prev_root) begin
							head_gran = hdr_next[cur];
							head_valid = hdr_nvalid[cur];
						end else begin
							hdr_next[prev] = hdr_next[cur];
							hdr_nvalid[prev] = hdr_nvalid[cur];
						end
						res.addr = payload_of(cur);
					end else begin
						n = cur + remain;
						hdr_size[cur] = remain;
						if (n < GRAN) begin
							hdr_size[n] = need;
							hdr_next[n] = 0;
							hdr_nvalid[n] = 1'b0;
						end
						res.addr = payload_of(n);
					end
					return res;
				end
				prev = cur;
				prev_root = 1'b0;
				cv = hdr_nvalid[cur];
				cur = hdr_next[cur];
			end
			res.status = ST_NOFIT;
			return res;
		end
		if (fa == '0) begin
			res.status = ST_NULL;
			return res;
		end
		off = fa - base_model;
		if (off < GRAN_SPAN || off >= ARENA_END) begin
			res.status = ST_RANGE;
			return res;
		end
		// Low address bits are dropped: the free hits the header granule just below the granule holding the address.
		b = int'(off >> GRAN_SHIFT) - 1;
		cur = 0;
		prev_root = 1'b1;
		nx = head_gran;
		nv = head_valid;
		for (steps = 0; nv && nx < b && steps < GRAN; steps++) begin
			cur = nx;
			prev_root = 1'b0;
			nv = hdr_nvalid[nx];
			nx = hdr_next[nx];
		end
		hdr_next[b] = nx;
		hdr_nvalid[b] = nv;
		if (prev_root) begin
			head_gran = b;
			head_valid = 1'b1;
		end else begin
			hdr_next[cur] = b;
			hdr_nvalid[cur] = 1'b1;
		end
		if (hdr_nvalid[b] && hdr_next[b] < GRAN && b + hdr_size[b] == hdr_next[b])
			join_blocks(b, hdr_next[b]);
		if (!prev_root && cur + hdr_size[cur] == b)
			join_blocks(cur, b);
		return res;
	endfunction

	function automatic void flag_mismatch(string msg);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	// Offers one request and waits for it to be taken; valid stays high afterward.
	task automatic issue_request(input logic op_i, input logic [REQ_W-1:0] req,
			input logic [ADDR_W-1:0] fa, input bit use_typed, input alloc_result_t typed,
			output alloc_result_t predicted);
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 16)) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= op_i;
		request_bytes <= req;
		free_address <= fa;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = predict_allocator(op_i, req, fa);
		owed_results.push_back(use_typed ? typed : predicted);
	endtask

	task automatic alloc_and_track(input logic [REQ_W-1:0] req, output alloc_result_t res);
		issue_request(OP_ALLOC, req, ADDR_W'({$urandom, $urandom}), 1'b0, '0, res);
		if (res.status == ST_OK)
			live_granules.push_back(int'((res.addr - base_model) >> GRAN_SHIFT) - 1);
	endtask

	task automatic random_request();
		alloc_result_t res;
		logic [REQ_W-1:0] req;
		logic [ADDR_W-1:0] fa, off;
		int sel, pick;
		sel = $urandom_range(0, 99);
		if (live_granules.size() == 0 || $urandom_range(0, 99) < 52) begin
			if (sel < 60)
				req = REQ_W'($urandom_range(1, 256));
			else if (sel < 85)
				req = REQ_W'($urandom_range(257, 2048));
			else if (sel < 96)
				req = REQ_W'($urandom_range(0, 65535));
			else
				req = '0;
			alloc_and_track(req, res);
		end else begin
			if (sel < 80) begin
				pick = $urandom_range(0, live_granules.size() - 1);
				fa = payload_of(live_granules[pick]) + ADDR_W'($urandom_range(0, GRAN_BYTES - 1));
				live_granules.delete(pick);
			end else if (sel < 90) begin
				fa = '0;
			end else begin
				off = ADDR_W'({$urandom, $urandom});
				if ($urandom_range(0, 1) == 0)
					off = ADDR_W'($urandom_range(0, GRAN_BYTES - 1));
				else if (off >= GRAN_SPAN && off < ARENA_END)
					off = off | ARENA_END;
				fa = base_model + off;
			end
			issue_request(OP_FREE, REQ_W'($urandom), fa, 1'b0, '0, res);
		end
	endtask

	task automatic write_arena_base(input logic [ADDR_W-1:0] value);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_base <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		base_model = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		alloc_result_t res, typed, first_blk, second_blk;
		logic [ADDR_W-1:0] next_base;
		for (int g = 0; g < GRAN; g++) begin
			hdr_size[g] = 0;
			hdr_next[g] = 0;
			hdr_nvalid[g] = 1'b0;
		end
		hdr_size[0] = GRAN;
		head_gran = 0;
		head_valid = 1'b1;
		base_model = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_OPENING; i++) begin
			typed.addr = opening[i].exp_addr;
			typed.status = opening[i].exp_status;
			issue_request(opening[i].op, opening[i].req, opening[i].faddr, opening[i].fixed,
				typed, res);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: next_base = '0;
				1: next_base = '1;
				2: next_base = 48'hFFFF_FFFF_F000;
				3: next_base = ADDR_W'({$urandom, $urandom}) & ~ADDR_W'(GRAN_BYTES - 1);
				default: next_base = ADDR_W'({$urandom, $urandom});
			endcase
			write_arena_base(next_base);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				quiet = (p == N_PHASES - 1) || (i % 50 < 10);
				// The output is held off long enough for the block to back up.
				if (p == 1 && i == 20)
					long_hold_req = 1'b1;
				random_request();
			end
			@(negedge clk);
			in_valid <= 1'b0;
		end

		// Release every live block, then free one block twice so that its header links
		// to itself and later walks must be cut off.
		while (live_granules.size() != 0)
			issue_request(OP_FREE, '0, payload_of(live_granules.pop_front()), 1'b0, '0, res);
		alloc_and_track(REQ_W'(64), first_blk);
		alloc_and_track(REQ_W'(64), second_blk);
		issue_request(OP_FREE, '0, first_blk.addr, 1'b0, '0, res);
		issue_request(OP_FREE, '0, first_blk.addr, 1'b0, '0, res);
		issue_request(OP_ALLOC, REQ_W'(4000), '0, 1'b0, '0, res);
		issue_request(OP_FREE, '0, second_blk.addr, 1'b0, '0, res);
		issue_request(OP_ALLOC, REQ_W'(1), '0, 1'b0, '0, res);
		issue_request(OP_ALLOC, REQ_W'(4000), '0, 1'b0, '0, res);
		@(negedge clk);
		in_valid <= 1'b0;

		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	always begin : receiver_stall
		int burst;
		@(negedge clk);
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			out_stall <= 1'b1;
			repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			burst = $urandom_range(1, 16);
			out_stall <= 1'b1;
			repeat (burst - 1) @(negedge clk);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		alloc_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_results.size() == 0) begin
				flag_mismatch($sformatf("result with none pending: block_address %h status %0d",
					block_address, status));
			end else begin
				want = owed_results.pop_front();
				if (block_address !== want.addr)
					flag_mismatch($sformatf("block_address expected %h, got %h",
						want.addr, block_address));
				if (status !== want.status)
					flag_mismatch($sformatf("status expected %0d, got %0d", want.status, status));
			end
		end
	end

	// Ends the run when no request, result or register write has moved for too long.
	always @(posedge clk) begin : watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
